### hw/rtl/cbg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbg_pkg
// Shared types, register codes and constant tables for the contrast,
// brightness and gamma pixel core.
// ----------------------------------------------------------------------------
package cbg_pkg;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_CONTRAST   = 3'd0,
        CFG_BRIGHTNESS = 3'd1,
        CFG_GAMMA      = 3'd2,
        CFG_LUMA       = 3'd3,
        CFG_THREE      = 3'd4
    } cfg_idx_t;

    // how the back end treats a pixel
    typedef enum logic [1:0] {
        MODE_GRAY  = 2'd0,
        MODE_COLOR = 2'd1,
        MODE_LUMA  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0] chan_blue;
        logic [7:0] chan_green;
        logic [7:0] chan_red;
    } pixel_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
    } result_t;

    typedef struct packed {
        logic [15:0]        contrast_gain;
        logic signed [16:0] brightness_offset;
        logic [15:0]        gamma_exponent;
        logic               luma_only;
        logic               three_channel;
    } cfg_t;

    typedef struct packed {
        pixel_t pix;
        mode_t  mode;
    } item_t;

    // write of one entry of the output lookup tables
    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } tab_wr_t;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef logic [15:0][30:0]  root_tab_t;
    typedef logic [255:0][30:0] mant_tab_t;
    typedef logic [255:0][3:0]  exp_tab_t;
    typedef logic [255:0][24:0] recip_tab_t;

    // integer square root, used at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = val;
        res = 64'd0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (b > v)
                b = b >> 2;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (b != 64'd0)
            begin
                if (v >= res + b)
                begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // roots 2^(2^-k) in Q30, first entry is sqrt(2)
    function automatic root_tab_t build_roots();
        root_tab_t   t;
        logic [63:0] r;
        r = isqrt64(64'd2 << 60);
        for (int j = 0; j < 16; j++)
        begin
            t[j] = r[30:0];
            r    = isqrt64(r << 30);
        end
        return t;
    endfunction

    // normalized mantissa of byte/255 in [1,2) Q30
    function automatic mant_tab_t build_mant();
        mant_tab_t   t;
        logic [63:0] v;
        for (int c = 0; c < 256; c++)
        begin
            v = 64'(c);
            for (int i = 0; i < 9; i++)
            begin
                if (v < 64'd255 && v != 64'd0)
                    v = v << 1;
            end
            t[c] = 31'((v << 30) / 64'd255);
        end
        return t;
    endfunction

    // number of doublings that bring a byte into [255,510)
    function automatic exp_tab_t build_exp();
        exp_tab_t    t;
        logic [15:0] v;
        logic [3:0]  e;
        for (int c = 0; c < 256; c++)
        begin
            v = 16'(c);
            e = 4'd0;
            for (int i = 0; i < 9; i++)
            begin
                if (v < 16'd255 && v != 16'd0)
                begin
                    v = v << 1;
                    e = e + 4'd1;
                end
            end
            t[c] = e;
        end
        return t;
    endfunction

    // ceil(2^24 / v), exact quotient for dividends below 2^16
    function automatic recip_tab_t build_recip();
        recip_tab_t t;
        t[0] = 25'd0;
        for (int c = 1; c < 256; c++)
        begin
            t[c] = 25'(((64'd1 << 24) + 64'(c) - 64'd1) / 64'(c));
        end
        return t;
    endfunction

    localparam root_tab_t  ROOT_TABLE  = build_roots();
    localparam mant_tab_t  MANT_TABLE  = build_mant();
    localparam exp_tab_t   EXP_TABLE   = build_exp();
    localparam recip_tab_t RECIP_TABLE = build_recip();

endpackage

### hw/rtl/cbg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbg_front
// Accepts pixel commands, classifies them by mode and queues them for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
module cbg_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            table_busy,
    input  cbg_pkg::pixel_t pixel,
    input  cbg_pkg::cfg_t   cfg,
    output logic            busy,
    output logic            item_valid,
    output cbg_pkg::item_t  item
);
    import cbg_pkg::*;

    item_t      queue_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;
    mode_t      mode;

    // classification
    always_comb
    begin
        if (!cfg.three_channel)
            mode = MODE_GRAY;
        else if (cfg.luma_only)
            mode = MODE_LUMA;
        else
            mode = MODE_COLOR;
    end

    assign busy       = table_busy || (count_reg == 2'd2);
    assign push       = start && !busy;
    assign pop        = (count_reg != 2'd0);
    assign item_valid = pop;
    assign item       = queue_mem[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            queue_mem[wr_ptr_reg] <= '{pix: pixel, mode: mode};
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

### hw/rtl/cbg_table_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbg_table_builder
// Sequencer that computes contrast * x^gamma + brightness for every byte
// value with shared log2, scale and exp2 steps and writes the output table.
// ----------------------------------------------------------------------------
module cbg_table_builder (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rebuild,
    input  cbg_pkg::cfg_t    cfg,
    output logic             busy,
    output cbg_pkg::tab_wr_t tab_wr
);
    import cbg_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SETUP  = 9'b000000010,
        ST_LOG    = 9'b000000100,
        ST_SCALE  = 9'b000001000,
        ST_DECIDE = 9'b000010000,
        ST_EXP    = 9'b000100000,
        ST_POST   = 9'b001000000,
        ST_MUL    = 9'b010000000,
        ST_FIN    = 9'b100000000
    } state_t;

    state_t      state_reg;
    logic [7:0]  idx_reg;
    logic [3:0]  step_reg;
    logic [30:0] m_reg;
    logic [3:0]  e_reg;
    logic [15:0] frac_reg;
    logic [23:0] t_reg;
    logic [15:0] q_reg;
    logic [31:0] p_reg;
    logic [30:0] y_reg;
    logic [54:0] prod_reg;

    logic [61:0]        sq;
    logic [31:0]        sq_top;
    logic [19:0]        neg_log;
    logic [35:0]        scale_prod;
    logic [62:0]        exp_prod;
    logic [7:0]         n_int;
    logic [15:0]        f_frac;
    logic [23:0]        k255;
    logic signed [57:0] bias;
    logic signed [57:0] s_sum;
    logic [57:0]        s_rnd;
    logic [15:0]        r_int;
    logic [7:0]         out_byte;

    // log2 squaring step
    assign sq      = 62'(m_reg) * 62'(m_reg);
    assign sq_top  = sq[61:30];

    // -log2 scaled by gamma
    assign neg_log    = {e_reg, 16'd0} - {4'd0, frac_reg};
    assign scale_prod = 36'(neg_log) * 36'(cfg.gamma_exponent);
    assign n_int      = t_reg[23:16];
    assign f_frac     = t_reg[15:0];

    // exp2 product step
    assign exp_prod = 63'(p_reg) * 63'(ROOT_TABLE[step_reg]);

    // final scale, offset, round and saturate
    assign k255   = {cfg.contrast_gain, 8'd0} - {8'd0, cfg.contrast_gain};
    assign bias   = {{7{cfg.brightness_offset[16]}}, cfg.brightness_offset, 34'd0};
    assign s_sum  = $signed({3'd0, prod_reg}) + bias;
    assign s_rnd  = s_sum + 58'(1) * (58'd1 << 41);
    assign r_int  = s_rnd[57:42];

    always_comb
    begin
        if (s_sum[57] || (s_sum == 58'sd0))
            out_byte = 8'd0;
        else if (r_int > 16'd255)
            out_byte = 8'd255;
        else
            out_byte = r_int[7:0];
    end

    assign busy          = (state_reg != ST_IDLE);
    assign tab_wr.en     = (state_reg == ST_FIN);
    assign tab_wr.addr   = idx_reg;
    assign tab_wr.data   = out_byte;

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SETUP;
            idx_reg   <= 8'd0;
            step_reg  <= 4'd0;
        end
        else if (rebuild)
        begin
            state_reg <= ST_SETUP;
            idx_reg   <= 8'd0;
            step_reg  <= 4'd0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_SETUP:
                begin
                    step_reg <= 4'd0;
                    if (cfg.gamma_exponent == 16'd0 || idx_reg == 8'd0 || idx_reg == 8'd255)
                        state_reg <= ST_MUL;
                    else
                        state_reg <= ST_LOG;
                end
                ST_LOG:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd15)
                        state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    step_reg <= 4'd0;
                    if (n_int >= 8'd31 || f_frac == 16'd0)
                        state_reg <= ST_MUL;
                    else
                        state_reg <= ST_EXP;
                end
                ST_EXP:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd15)
                        state_reg <= ST_POST;
                end
                ST_POST:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (idx_reg == 8'd255)
                        state_reg <= ST_IDLE;
                    else
                    begin
                        idx_reg   <= idx_reg + 8'd1;
                        state_reg <= ST_SETUP;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_SETUP:
            begin
                m_reg    <= MANT_TABLE[idx_reg];
                e_reg    <= EXP_TABLE[idx_reg];
                frac_reg <= 16'd0;
                if (cfg.gamma_exponent == 16'd0 || idx_reg == 8'd255)
                    y_reg <= ONE_Q30;
                else
                    y_reg <= 31'd0;
            end
            ST_LOG:
            begin
                if (sq_top[31])
                begin
                    m_reg    <= sq_top[31:1];
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_reg    <= sq_top[30:0];
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
            end
            ST_SCALE:
            begin
                t_reg <= scale_prod[35:12];
            end
            ST_DECIDE:
            begin
                q_reg <= 16'd0 - f_frac;
                p_reg <= {1'b0, ONE_Q30};
                if (n_int >= 8'd31)
                    y_reg <= 31'd0;
                else
                    y_reg <= ONE_Q30 >> n_int;
            end
            ST_EXP:
            begin
                if (q_reg[4'd15 - step_reg])
                    p_reg <= exp_prod[61:30];
            end
            ST_POST:
            begin
                y_reg <= 31'(p_reg >> (9'(n_int) + 9'd1));
            end
            ST_MUL:
            begin
                prod_reg <= 55'(k255) * 55'(y_reg);
            end
            default:
            begin
            end
        endcase
    end

endmodule

### hw/rtl/cbg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbg_back
// Pixel pipeline: output table lookups for gray and color pixels, value
// scaling with a reciprocal divide for luma pixels, result register.
// ----------------------------------------------------------------------------
module cbg_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  cbg_pkg::item_t    item,
    input  cbg_pkg::cfg_t     cfg,
    input  cbg_pkg::tab_wr_t  tab_wr,
    output logic              done,
    output cbg_pkg::result_t  result
);
    import cbg_pkg::*;

    // one copy of the table per read port
    logic [7:0] tab_b [256];
    logic [7:0] tab_g [256];
    logic [7:0] tab_r [256];

    logic [5:1] vld_reg;
    logic       done_reg;
    result_t    result_reg;

    logic [2:0][7:0]  ch1_reg, ch2_reg;
    mode_t            mode1_reg, mode2_reg, mode3_reg, mode4_reg, mode5_reg;
    logic [7:0]       v1_reg, v2_reg, v3_reg, v4_reg;
    logic [2:0][7:0]  tab1_reg, tab2_reg, tab3_reg, tab4_reg, tab5_reg;
    logic [23:0]      vc1_reg;
    logic signed [34:0] vp2_reg;
    logic [2:0][41:0] prod3_reg;
    logic             pos3_reg, pos4_reg, pos5_reg;
    logic             vz3_reg, vz4_reg, vz5_reg;
    logic [7:0]       zr3_reg, zr4_reg, zr5_reg;
    logic [2:0][15:0] x4_reg;
    logic [2:0]       sat4_reg, sat5_reg;
    logic [2:0][7:0]  q5_reg;

    logic [7:0]       vmax;
    logic [2:0][7:0]  ch0;
    logic signed [34:0] vp_next;
    logic [33:0]      vpu;
    logic [34:0]      zr_sum;
    logic [7:0]       zr_next;
    logic [2:0][41:0] prod_next;
    logic [2:0][41:0] num_next;
    logic [2:0][40:0] qprod;
    result_t          res_next;

    assign ch0[0] = item.pix.chan_blue;
    assign ch0[1] = item.pix.chan_green;
    assign ch0[2] = item.pix.chan_red;

    // largest channel
    always_comb
    begin
        vmax = ch0[0];
        if (ch0[1] > vmax)
            vmax = ch0[1];
        if (ch0[2] > vmax)
            vmax = ch0[2];
    end

    // table write port
    always_ff @(posedge clk)
    begin
        if (tab_wr.en)
        begin
            tab_b[tab_wr.addr] <= tab_wr.data;
            tab_g[tab_wr.addr] <= tab_wr.data;
            tab_r[tab_wr.addr] <= tab_wr.data;
        end
    end

    // stage 1: table reads and value times contrast
    always_ff @(posedge clk)
    begin
        tab1_reg[0] <= tab_b[ch0[0]];
        tab1_reg[1] <= tab_g[ch0[1]];
        tab1_reg[2] <= tab_r[ch0[2]];
        ch1_reg     <= ch0;
        mode1_reg   <= item.mode;
        v1_reg      <= vmax;
        vc1_reg     <= 24'(vmax) * 24'(cfg.contrast_gain);
    end

    // stage 2: new value with brightness, 20 fraction bits
    assign vp_next = $signed({3'd0, vc1_reg, 8'd0})
                   + $signed({{6{cfg.brightness_offset[16]}}, cfg.brightness_offset, 12'd0});

    always_ff @(posedge clk)
    begin
        vp2_reg   <= vp_next;
        ch2_reg   <= ch1_reg;
        mode2_reg <= mode1_reg;
        v2_reg    <= v1_reg;
        tab2_reg  <= tab1_reg;
    end

    // stage 3: channel times new value, rounded value for a black pixel
    assign vpu    = vp2_reg[33:0];
    assign zr_sum = 35'(vpu) + (35'd1 << 19);
    assign zr_next = (zr_sum[34:20] > 15'd255) ? 8'd255 : zr_sum[27:20];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = 42'(ch2_reg[i]) * 42'(vpu);
        end
    end

    always_ff @(posedge clk)
    begin
        prod3_reg <= prod_next;
        pos3_reg  <= !vp2_reg[34] && (vp2_reg != 35'sd0);
        vz3_reg   <= (v2_reg == 8'd0);
        zr3_reg   <= zr_next;
        mode3_reg <= mode2_reg;
        v3_reg    <= v2_reg;
        tab3_reg  <= tab2_reg;
    end

    // stage 4: rounding bias, integer part and saturation test
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = prod3_reg[i] + {15'd0, v3_reg, 19'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            x4_reg[i]   <= num_next[i][35:20];
            sat4_reg[i] <= (num_next[i][41:20] >= {6'd0, v3_reg, 8'd0});
        end
        pos4_reg  <= pos3_reg;
        vz4_reg   <= vz3_reg;
        zr4_reg   <= zr3_reg;
        mode4_reg <= mode3_reg;
        v4_reg    <= v3_reg;
        tab4_reg  <= tab3_reg;
    end

    // stage 5: divide by the value through its reciprocal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qprod[i] = 41'(x4_reg[i]) * 41'(RECIP_TABLE[v4_reg]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            q5_reg[i] <= qprod[i][31:24];
        end
        sat5_reg  <= sat4_reg;
        pos5_reg  <= pos4_reg;
        vz5_reg   <= vz4_reg;
        zr5_reg   <= zr4_reg;
        mode5_reg <= mode4_reg;
        tab5_reg  <= tab4_reg;
    end

    // result select
    always_comb
    begin
        logic [2:0][7:0] lum;
        for (int i = 0; i < 3; i++)
        begin
            if (!pos5_reg)
                lum[i] = 8'd0;
            else if (vz5_reg)
                lum[i] = zr5_reg;
            else if (sat5_reg[i])
                lum[i] = 8'd255;
            else
                lum[i] = q5_reg[i];
        end
        case (mode5_reg)
            MODE_GRAY:
            begin
                res_next = '{out_blue: tab5_reg[0], out_green: 8'd0, out_red: 8'd0};
            end
            MODE_COLOR:
            begin
                res_next = '{out_blue: tab5_reg[0], out_green: tab5_reg[1],
                             out_red: tab5_reg[2]};
            end
            MODE_LUMA:
            begin
                res_next = '{out_blue: lum[0], out_green: lum[1], out_red: lum[2]};
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
    end

    // valid bits along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[4:1], item_valid};
            done_reg <= vld_reg[5];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### hw/rtl/contrast_brightness_gamma_pixel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contrast_brightness_gamma_pixel_core
// Contrast, brightness and gamma adjustment of one pixel per clock while no table rebuild holds busy high.
// ----------------------------------------------------------------------------
// Done rises once a taken pixel has passed the queue, the back-end stages and
// the result register. Throughput: one pixel per cycle outside table rebuilds,
// set by the fully pipelined back end. After reset and after any write of
// contrast, brightness or gamma, busy is high while the output table for all
// 256 byte values is rebuilt in the shared log2/exp2 sequencer.
// Results cannot be stalled; configuration writes are always taken.
module contrast_brightness_gamma_pixel_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cbg_pkg::pixel_t   pixel,
    output logic              done,
    output cbg_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [16:0]       cfg_data
);
    import cbg_pkg::*;

    cfg_t    cfg_reg;
    logic    cfg_wr;
    logic    rebuild;
    logic    table_busy;
    tab_wr_t tab_wr;
    logic    item_valid;
    item_t   item;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign rebuild   = cfg_wr && (cfg_index == CFG_CONTRAST || cfg_index == CFG_BRIGHTNESS
                                  || cfg_index == CFG_GAMMA);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.contrast_gain     <= 16'd4096;
            cfg_reg.brightness_offset <= 17'sd0;
            cfg_reg.gamma_exponent    <= 16'd4096;
            cfg_reg.luma_only         <= 1'b0;
            cfg_reg.three_channel     <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_CONTRAST:   cfg_reg.contrast_gain     <= cfg_data[15:0];
                CFG_BRIGHTNESS: cfg_reg.brightness_offset <= $signed(cfg_data);
                CFG_GAMMA:      cfg_reg.gamma_exponent    <= cfg_data[15:0];
                CFG_LUMA:       cfg_reg.luma_only         <= cfg_data[0];
                CFG_THREE:      cfg_reg.three_channel     <= cfg_data[0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // table sequencer
    cbg_table_builder u_builder (
        .clk     (clk),
        .rst_n   (rst_n),
        .rebuild (rebuild),
        .cfg     (cfg_reg),
        .busy    (table_busy),
        .tab_wr  (tab_wr)
    );

    // command intake and queue
    cbg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .table_busy (table_busy),
        .pixel      (pixel),
        .cfg        (cfg_reg),
        .busy       (busy),
        .item_valid (item_valid),
        .item       (item)
    );

    // pixel pipeline
    cbg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .cfg        (cfg_reg),
        .tab_wr     (tab_wr),
        .done       (done),
        .result     (result)
    );

endmodule

### tb/contrast_brightness_gamma_pixel_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contrast_brightness_gamma_pixel_core_tb
// Self-checking bench for the pixel core. A bit-exact predictor of the
// gamma, contrast, brightness and luma arithmetic computes each expected
// pixel; a checker compares every done strobe with the oldest prediction.
// Directed corner cases are followed by randomized register settings and
// pixels, with random start gaps.
// ----------------------------------------------------------------------------
module contrast_brightness_gamma_pixel_core_tb;
    import cbg_pkg::*;

    localparam logic [2:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [2:0] CFG_UNUSED_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    pixel_t      pixel;
    logic        done;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    // shadow of the register file
    logic [15:0]        sh_contrast;
    logic signed [16:0] sh_bright;
    logic [15:0]        sh_gamma;
    logic               sh_luma;
    logic               sh_three;

    result_t     pending_pixels[$];
    int          errors;
    int          idle_pct;

    contrast_brightness_gamma_pixel_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // integer square root
    function automatic logic [63:0] int_sqrt(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = val;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(q/65536) in q30
    function automatic logic [63:0] exp2_fraction(input logic [31:0] q);
        logic [63:0] p;
        logic [63:0] r;
        p = 64'd1 << 30;
        r = int_sqrt(64'd2 << 60);
        for (int k = 15; k >= 0; k--)
        begin
            if (q[k])
                p = (p * r) >> 30;
            r = int_sqrt(r << 30);
        end
        return p;
    endfunction

    // 16-bit fraction of log2 of a q30 mantissa in [1,2)
    function automatic logic [31:0] log2_fraction(input logic [63:0] mant);
        logic [63:0] m;
        logic [31:0] frac;
        m    = mant;
        frac = 0;
        for (int i = 0; i < 16; i++)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30))
            begin
                frac = frac | 32'd1;
                m    = m >> 1;
            end
        end
        return frac;
    endfunction

    // byte/255 raised to gamma, q30
    function automatic logic [63:0] gamma_curve(input logic [7:0] c, input logic [15:0] g);
        logic [63:0] v;
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] f;
        if (g == 0)
            return 64'd1 << 30;
        if (c == 0)
            return 0;
        if (c == 8'd255)
            return 64'd1 << 30;
        v = c;
        e = 0;
        while (v < 255)
        begin
            v = v << 1;
            e = e + 1;
        end
        m = (v << 30) / 64'd255;
        t = ((e * 65536 - log2_fraction(m)) * g) >> 12;
        n = t >> 16;
        f = t & 64'hFFFF;
        if (n >= 31)
            return 0;
        if (f == 0)
            return (64'd1 << 30) >> n;
        return exp2_fraction(32'(65536 - f)) >> (n + 1);
    endfunction

    // normal mode: contrast * x^gamma + brightness, rounded and saturated
    function automatic logic [7:0] adjust_channel(input logic [7:0] c);
        logic signed [63:0] s;
        logic [63:0]        r;
        s = $signed(64'd255 * sh_contrast * gamma_curve(c, sh_gamma))
            + 64'(sh_bright) * (64'sd1 <<< 34);
        if (s <= 0)
            return 8'd0;
        r = (64'(s) + (64'd1 << 41)) >> 42;
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function automatic result_t adjust_pixel(input pixel_t p);
        result_t            o;
        logic [7:0]         ch[3];
        logic [7:0]         vmax;
        logic signed [63:0] vp;
        logic [63:0]        r;
        logic [63:0]        den;
        logic [7:0]         res[3];
        ch[0] = p.chan_blue;
        ch[1] = p.chan_green;
        ch[2] = p.chan_red;
        if (!sh_three)
        begin
            o.out_blue  = adjust_channel(ch[0]);
            o.out_green = 8'd0;
            o.out_red   = 8'd0;
            return o;
        end
        if (!sh_luma)
        begin
            o.out_blue  = adjust_channel(ch[0]);
            o.out_green = adjust_channel(ch[1]);
            o.out_red   = adjust_channel(ch[2]);
            return o;
        end
        // luma mode: scale every channel by V'/V
        vmax = ch[0];
        if (ch[1] > vmax) vmax = ch[1];
        if (ch[2] > vmax) vmax = ch[2];
        vp = 64'(vmax) * 64'(sh_contrast) * 256 + 64'(sh_bright) * 4096;
        for (int i = 0; i < 3; i++)
        begin
            if (vp <= 0)
                r = 0;
            else if (vmax == 0)
                r = (64'(vp) + (64'd1 << 19)) >> 20;
            else
            begin
                den = 64'(vmax) << 20;
                r   = (2 * 64'(ch[i]) * 64'(vp) + den) / (2 * den);
            end
            res[i] = (r > 255) ? 8'd255 : r[7:0];
        end
        o.out_blue  = res[0];
        o.out_green = res[1];
        o.out_red   = res[2];
        return o;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, field, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("ERROR %0t: result with no transaction pending", $time);
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (result.out_blue !== want.out_blue)
                    report_mismatch("out_blue", result.out_blue, want.out_blue);
                if (result.out_green !== want.out_green)
                    report_mismatch("out_green", result.out_green, want.out_green);
                if (result.out_red !== want.out_red)
                    report_mismatch("out_red", result.out_red, want.out_red);
            end
        end
    end

    // send one pixel, record its prediction when taken
    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        pixel_t p;
        p.chan_blue  = b;
        p.chan_green = g;
        p.chan_red   = r;
        @(negedge clk);
        start <= 1'b1;
        pixel <= p;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_pixels.push_back(adjust_pixel(p));
        if ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(3)) @(negedge clk);
        end
    endtask

    task automatic send_random_pixel();
        logic [7:0] c[3];
        for (int i = 0; i < 3; i++)
        begin
            case ($urandom_range(7))
                0:       c[i] = 8'd0;
                1:       c[i] = 8'd255;
                default: c[i] = 8'($urandom);
            endcase
        end
        send_pixel(c[0], c[1], c[2]);
    endtask

    // drain the pipeline before touching registers
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            CFG_CONTRAST:   sh_contrast = val[15:0];
            CFG_BRIGHTNESS: sh_bright   = $signed(val);
            CFG_GAMMA:      sh_gamma    = val[15:0];
            CFG_LUMA:       sh_luma     = val[0];
            CFG_THREE:      sh_three    = val[0];
            default:        ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(input logic [15:0] con, input logic [16:0] bri,
                           input logic [15:0] gam, input logic luma, input logic three);
        wait_idle();
        write_reg(CFG_CONTRAST, 17'(con));
        write_reg(CFG_BRIGHTNESS, bri);
        write_reg(CFG_GAMMA, 17'(gam));
        write_reg(CFG_LUMA, 17'(luma));
        write_reg(CFG_THREE, 17'(three));
    endtask

    // reset values, channel extremes
    task automatic test_reset_defaults();
        idle_pct = 0;
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd128, 8'd254);
        send_pixel(8'h55, 8'hAA, 8'h0F);
    endtask

    // gamma zero, extreme contrast and brightness, unused indexes
    task automatic test_gamma_extremes();
        set_all(16'd4096, 17'd0, 16'd0, 1'b0, 1'b1);
        send_pixel(8'd0, 8'd7, 8'd255);
        set_all(16'hFFFF, 17'(-65280), 16'hFFFF, 1'b0, 1'b1);
        send_pixel(8'd0, 8'd254, 8'd255);
        send_pixel(8'd200, 8'd100, 8'd1);
        set_all(16'd0, 17'd65280, 16'd1, 1'b0, 1'b1);
        send_pixel(8'd0, 8'd1, 8'd255);
        wait_idle();
        write_reg(CFG_UNUSED_LO, 17'h1FFFF);
        write_reg(CFG_UNUSED_HI, 17'h0ABCD);
        // brightness beyond its nominal range
        set_all(16'd2048, 17'h10000, 16'd8192, 1'b0, 1'b1);
        send_pixel(8'd3, 8'd128, 8'd255);
        set_all(16'd6000, 17'h0FFFF, 16'd2048, 1'b0, 1'b1);
        send_pixel(8'd3, 8'd128, 8'd255);
    endtask

    // luma mode, including black pixels and a gray pixel with luma set
    task automatic test_luma_mode();
        set_all(16'd8192, 17'd1000, 16'd4096, 1'b1, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd10, 8'd200, 8'd90);
        send_pixel(8'd255, 8'd0, 8'd128);
        set_all(16'd4096, 17'(-30000), 16'd4096, 1'b1, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd100, 8'd250, 8'd50);
        set_all(16'd3000, 17'd500, 16'd12000, 1'b1, 1'b0);
        send_pixel(8'd77, 8'd200, 8'd200);
        send_pixel(8'd255, 8'd1, 8'd1);
    endtask

    // random register settings and pixels
    task automatic test_random_pixels();
        int pcts[3] = '{0, 49, 27};
        logic [15:0] con;
        logic [15:0] gam;
        logic [16:0] bri;
        for (int ph = 0; ph < 9; ph++)
        begin
            case ($urandom_range(3))
                0:       con = 16'($urandom_range(2048, 8192));
                1:       con = (ph % 2) ? 16'hFFFF : 16'd0;
                default: con = 16'($urandom);
            endcase
            case ($urandom_range(3))
                0:       gam = 16'($urandom_range(1024, 12288));
                1:       gam = (ph % 2) ? 16'd1 : 16'hFFFF;
                default: gam = 16'($urandom);
            endcase
            bri = ($urandom_range(1)) ? 17'($urandom_range(0, 20000) - 10000)
                                      : 17'($urandom);
            set_all(con, bri, gam, 1'($urandom_range(1)), 1'($urandom_range(3) != 0));
            for (int i = 0; i < 148; i++)
            begin
                if (i % 47 == 0)
                    idle_pct = pcts[(i / 47 + ph) % 3];
                send_random_pixel();
            end
        end
    endtask

    initial
    begin
        errors    = 0;
        idle_pct  = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        pixel     = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CONTRAST;
        cfg_data  = '0;
        sh_contrast = 16'd4096;
        sh_bright   = '0;
        sh_gamma    = 16'd4096;
        sh_luma     = 1'b0;
        sh_three    = 1'b1;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_gamma_extremes();
        test_luma_mode();
        test_random_pixels();

        wait_idle();
        if (errors == 0)
            $display("contrast_brightness_gamma_pixel_core: match");
        else
            $display("contrast_brightness_gamma_pixel_core: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("contrast_brightness_gamma_pixel_core: mismatch");
        $finish;
    end

endmodule
